// ===== hw/rtl/gunc_pkg.sv =====
// ----------------------------------------------------------------------------
// gunc_pkg
// shared types, codes and floating-point helpers for the gradient unscale block
// ----------------------------------------------------------------------------
package gunc_pkg;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    localparam logic       REG_RECIP_SCALE = 1'b0;
    localparam logic       REG_FORMAT      = 1'b1;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    typedef struct packed {
        logic [31:0] val;
        logic        nonfin;
        logic        restart;
        logic [1:0]  fmt;
        logic        bypass;
    } stage_t;

    function automatic logic is_nan32(input logic [31:0] x);
        is_nan32 = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [9:0]  mn;
        logic [3:0]  lz;
        logic [31:0] r;
        e  = h[14:10];
        m  = h[9:0];
        lz = 4'd0;
        for (int i = 9; i >= 0; i--) begin
            if (m[i] && lz == 4'd0) begin
                lz = 4'(10 - i);
            end
        end
        mn = 10'(m << lz);
        if (e == 5'd31) begin
            r = {h[15], 8'hFF, m, 13'd0};
        end else if (e == 5'd0) begin
            if (m == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                r = {h[15], 8'(8'd113 - 8'(lz)), mn, 13'd0};
            end
        end else begin
            r = {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
        end
        fp16_to_fp32 = r;
    endfunction

    function automatic logic [15:0] fp32_to_fp16(input logic [31:0] x);
        logic [7:0]  e;
        logic [23:0] full;
        logic [4:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [15:0] r;
        logic [15:0] sum;
        e    = x[30:23];
        full = {1'b1, x[22:0]};
        sh   = 5'd13;
        if (e < 8'd113) begin
            sh = 5'(8'd126 - e);
        end
        q    = full >> sh;
        rem  = full & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 24'd1;
        end
        sum = 16'({e - 8'd113, 10'd0}) + 16'(q);
        if (e == 8'hFF) begin
            r = {x[31], (x[22:0] != 23'd0) ? 15'h7E00 : 15'h7C00};
        end else if (e == 8'd0) begin
            r = {x[31], 15'd0};
        end else if (e >= 8'd143) begin
            r = {x[31], 15'h7C00};
        end else if (e >= 8'd113) begin
            r = {x[31], sum[14:0]};
        end else if (e < 8'd102) begin
            r = {x[31], 15'd0};
        end else begin
            r = {x[31], q[14:0]};
        end
        fp32_to_fp16 = r;
    endfunction

    function automatic logic [15:0] fp32_to_bf16(input logic [31:0] x);
        logic [32:0] s;
        s = 33'(x) + 33'h7FFF + 33'(x[16]);
        fp32_to_bf16 = is_nan32(x) ? 16'h7FC0 : s[31:16];
    endfunction

endpackage

// ===== hw/rtl/gunc_widen.sv =====
// ----------------------------------------------------------------------------
// gunc_widen
// input register stage: widens the element to fp32 and flags non-finite values
// ----------------------------------------------------------------------------
module gunc_widen (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          grad_bits,
    input  logic                 restart,
    input  logic [1:0]           fmt,
    input  logic                 bypass,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gunc_pkg::stage_t     out_stage
);
    import gunc_pkg::*;

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_comb begin
        stage_next         = '0;
        stage_next.restart = restart;
        stage_next.fmt     = fmt;
        stage_next.bypass  = bypass;
        case (fmt)
            FMT_FP16: stage_next.val = fp16_to_fp32(grad_bits[15:0]);
            FMT_BF16: stage_next.val = {grad_bits[15:0], 16'd0};
            default:  stage_next.val = grad_bits;
        endcase
        stage_next.nonfin = (stage_next.val[30:23] == 8'hFF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            stage_reg <= stage_next;
        end
    end
endmodule

// ===== hw/rtl/gunc_mul.sv =====
// ----------------------------------------------------------------------------
// gunc_mul
// fp32 multiply by the inverse scale with round-to-nearest-even
// ----------------------------------------------------------------------------
module gunc_mul (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import gunc_pkg::*;

    logic        sgn;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [4:0]  lza;
    logic [4:0]  lzb;
    logic [47:0] prod;
    logic [47:0] pn;
    logic signed [10:0] ex;
    logic [5:0]  rsh;
    logic [47:0] sticky_mask;
    logic [49:0] pw;
    logic [24:0] mant;
    logic        g;
    logic        st;
    logic [24:0] mr;
    logic [7:0]  eout;

    always_comb begin
        sgn = a[31] ^ b[31];
        ea  = a[30:23];
        eb  = b[30:23];
        ma  = {ea != 8'd0, a[22:0]};
        mb  = {eb != 8'd0, b[22:0]};
        lza = 5'd0;
        lzb = 5'd0;
        for (int i = 22; i >= 0; i--) begin
            if (ma[i] && lza == 5'd0 && ea == 8'd0) begin
                lza = 5'(23 - i);
            end
            if (mb[i] && lzb == 5'd0 && eb == 8'd0) begin
                lzb = 5'(23 - i);
            end
        end
        prod = 48'(ma) * 48'(mb);
        pn   = prod << (6'(lza) + 6'(lzb));
        // exponent of bit 46 position
        ex = 11'(ea) + 11'(ea == 8'd0) + 11'(eb) + 11'(eb == 8'd0) - 11'sd127
             - 11'(lza) - 11'(lzb);
        if (pn[47]) begin
            ex = ex + 11'sd1;
        end else begin
            pn = pn << 1;
        end
        // pn[47] is leading one, value exponent ex
        rsh = 6'd0;
        if (ex < 11'sd1) begin
            rsh = (ex < -11'sd30) ? 6'd32 : 6'(11'sd1 - ex);
        end
        pw          = {pn, 2'b00} >> rsh;
        sticky_mask = (48'd1 << rsh) - 48'd1;
        mant        = {1'b0, pw[49:26]};
        g           = pw[25];
        st          = (pw[24:0] != 25'd0) || ((pn & sticky_mask) != 48'd0);
        mr          = mant + 25'(g && (st || mant[0]));
        if (ex < 11'sd1) begin
            eout = mr[23] ? 8'd1 : 8'd0;
        end else if (mr[24]) begin
            eout = 8'(ex + 11'sd1);
        end else begin
            eout = 8'(ex);
        end
        if (is_nan32(a)) begin
            y = a | 32'h0040_0000;
        end else if (is_nan32(b)) begin
            y = b | 32'h0040_0000;
        end else if ((ea == 8'hFF && b[30:0] == 31'd0) ||
                     (eb == 8'hFF && a[30:0] == 31'd0)) begin
            y = QNAN_BITS;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            y = {sgn, 8'hFF, 23'd0};
        end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            y = {sgn, 31'd0};
        end else if (ex > 11'sd254 || (ex >= 11'sd1 && mr[24] && ex == 11'sd254)) begin
            y = {sgn, 8'hFF, 23'd0};
        end else if (mr[24]) begin
            y = {sgn, eout, mr[23:1]};
        end else begin
            y = {sgn, eout, mr[22:0]};
        end
    end
endmodule

// ===== hw/rtl/grad_unscale_nonfinite_check.sv =====
// ----------------------------------------------------------------------------
// grad_unscale_nonfinite_check
// gradient unscale with sticky non-finite detection for fp32, fp16 and bf16
//
//  channel  | ports                                             | dir
//  s_       | s_valid s_ready s_grad_bits s_restart             | in
//  m_       | m_valid m_ready m_unscaled_bits m_element_nonfinite m_found_any | out
//
//  one word per cycle while m_ready holds; input register, then result register
//  the fp32 multiplier sits between the two registers
//  reset clears valid flags and the found flag, scale resets to 1.0, format to fp32
//  a stalled result register holds the input register, which then stalls s_
// ----------------------------------------------------------------------------
module grad_unscale_nonfinite_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_grad_bits,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_unscaled_bits,
    output logic        m_element_nonfinite,
    output logic        m_found_any
);
    import gunc_pkg::*;

    logic [31:0] recip_scale_reg;
    logic [1:0]  fmt_reg;
    logic        found_reg;
    logic        found_next;
    logic        st_valid;
    logic        st_ready;
    stage_t      st;
    logic [31:0] prod;
    logic [31:0] res;
    logic [31:0] out_next;
    logic        valid_reg;
    logic [31:0] bits_reg;
    logic        nonfin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_scale_reg <= ONE_BITS;
            fmt_reg         <= FMT_FP32;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RECIP_SCALE: recip_scale_reg <= cfg_data;
                REG_FORMAT:      fmt_reg         <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    gunc_widen u_widen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .grad_bits (s_grad_bits),
        .restart   (s_restart),
        .fmt       (fmt_reg),
        .bypass    (recip_scale_reg == ONE_BITS),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_stage (st)
    );

    gunc_mul u_mul (
        .a (st.val),
        .b (recip_scale_reg),
        .y (prod)
    );

    assign st_ready = !valid_reg || m_ready;
    assign res      = st.bypass ? st.val : prod;

    always_comb begin
        case (st.fmt)
            FMT_FP16: out_next = {16'd0, fp32_to_fp16(res)};
            FMT_BF16: out_next = {16'd0, fp32_to_bf16(res)};
            default:  out_next = res;
        endcase
        found_next = (found_reg && !st.restart) || st.nonfin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (st_ready) begin
                valid_reg <= st_valid;
            end
            if (st_valid && st_ready) begin
                found_reg <= found_next;
            end
        end
        if (st_valid && st_ready) begin
            bits_reg   <= out_next;
            nonfin_reg <= st.nonfin;
        end
    end

    assign m_valid             = valid_reg;
    assign m_unscaled_bits     = bits_reg;
    assign m_element_nonfinite = nonfin_reg;
    assign m_found_any         = found_reg;
endmodule
